### rtl/core/mlp_posture_classifier_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MLP_POSTURE_CLASSIFIER_CORE_DEFINES_SVH
`define MLP_POSTURE_CLASSIFIER_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequence on the next edge.
`define MPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
// Assert a same-cycle implication.
`define MPC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`endif

### rtl/core/mpc_pkg.sv
// -----------------------------------------------------------------------------
// mpc_pkg
// Types, weight ROM and arithmetic helpers of the posture classifier.
// -----------------------------------------------------------------------------
package mpc_pkg;

    localparam int FEATURE_WIDTH = 16;
    localparam int WEIGHT_WIDTH  = 16;
    localparam int LOGIT_WIDTH   = 24;
    localparam int FRAC_BITS     = WEIGHT_WIDTH - 2;
    localparam int N_IN  = 4;
    localparam int N_H1  = 8;
    localparam int N_H2  = 4;
    localparam int N_OUT = 3;
    localparam int ACC_WIDTH = 48;
    localparam int CLASS_WIDTH = 2;

    // Layer selects of the shared layer module.
    localparam logic [1:0] LAYER_IN  = 2'd0;
    localparam logic [1:0] LAYER_HID = 2'd1;
    localparam logic [1:0] LAYER_OUT = 2'd2;

    typedef logic signed [FEATURE_WIDTH-1:0] feat_t;
    typedef logic signed [WEIGHT_WIDTH-1:0]  wgt_t;
    typedef logic signed [LOGIT_WIDTH-1:0]   logit_t;
    typedef logic signed [ACC_WIDTH-1:0]     acc_t;

    typedef enum logic [CLASS_WIDTH-1:0] {
        CLASS_UPRIGHT  = 2'd0,
        CLASS_FORWARD  = 2'd1,
        CLASS_BACKWARD = 2'd2
    } class_t;

    typedef struct packed {
        feat_t pitch;
        feat_t roll;
        feat_t pitch_omega;
        feat_t roll_omega;
    } in_beat_t;

    typedef struct packed {
        logic [CLASS_WIDTH-1:0] posture;
        logic signed [LOGIT_WIDTH-1:0] score;
        logic signed [LOGIT_WIDTH-1:0] logit_upright;
        logic signed [LOGIT_WIDTH-1:0] logit_forward;
        logic signed [LOGIT_WIDTH-1:0] logit_backward;
    } out_beat_t;

    // Coefficients in hundredths.
    localparam int L1_W [N_IN*N_H1] = '{
         45, -32,  18,  67, -21,  53, -44,  11,
        -38,  72, -15,  29,  61, -47,  33, -56,
         22, -19,  84, -41,  16,  58, -27,  43,
        -51,  36, -63,  25, -34,  71,  48, -17};
    localparam int L1_B [N_H1] = '{10, -5, 8, -12, 3, 15, -7, 2};
    localparam int L2_W [N_H1*N_H2] = '{
         39, -28,  52, -17, -43,  61, -35,  24,
         31, -54,  46, -22, -37,  48, -19,  63,
         26, -41,  57, -33, -15,  38, -52,  44,
         49, -23,  36, -58, -31,  55, -42,  27};
    localparam int L2_B [N_H2] = '{6, -3, 9, -4};
    localparam int L3_W [N_H2*N_OUT] = '{
         74, -58, -31, -42,  65, -27,  33, -49,  62, -21,  38,  56};
    localparam int L3_B [N_OUT] = '{15, -8, -5};

    // Quantize hundredths to Q1.F, round half away from zero (elaboration only).
    function automatic longint quant(input int h);
        longint num;
        num = longint'(h) * (longint'(1) << FRAC_BITS);
        if (num >= 0) return (num * 2 + 100) / 200;
        return -((-num * 2 + 100) / 200);
    endfunction

    // Round to input scale (half up), optional ReLU, saturate.
    function automatic logit_t scale_sat(input acc_t acc, input logic relu);
        acc_t t;
        acc_t q;
        logit_t hi;
        logit_t lo;
        t = acc + (acc_t'(1) <<< (FRAC_BITS - 1));
        q = t >>> FRAC_BITS;
        hi = {1'b0, {(LOGIT_WIDTH-1){1'b1}}};
        lo = {1'b1, {(LOGIT_WIDTH-1){1'b0}}};
        if (relu && q < 0) return '0;
        if (q > acc_t'(hi)) return hi;
        if (q < acc_t'(lo)) return lo;
        return q[LOGIT_WIDTH-1:0];
    endfunction

endpackage

### rtl/core/mpc_layer.sv
// -----------------------------------------------------------------------------
// mpc_layer
// One fully connected layer in two stages: products, then sum and scale.
// -----------------------------------------------------------------------------
module mpc_layer (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic [1:0]              layer_sel,
    input  mpc_pkg::logit_t         src [mpc_pkg::N_H1],
    output mpc_pkg::logit_t         dst [mpc_pkg::N_H1]
);
    localparam int NS = mpc_pkg::N_H1;
    localparam int ND = mpc_pkg::N_H1;

    mpc_pkg::acc_t prod_reg [ND][NS];
    mpc_pkg::acc_t prod_next [ND][NS];
    mpc_pkg::logit_t dst_reg [ND];
    mpc_pkg::logit_t dst_next [ND];

    // Form products against the constant coefficients of the selected layer.
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            for (int s = 0; s < NS; s++) begin
                prod_next[d][s] = '0;
                case (layer_sel)
                    mpc_pkg::LAYER_IN: if (d < mpc_pkg::N_H1 && s < mpc_pkg::N_IN)
                        prod_next[d][s] = mpc_pkg::acc_t'(src[s]) * mpc_pkg::acc_t'(
                            mpc_pkg::quant(mpc_pkg::L1_W[s*mpc_pkg::N_H1+d]));
                    mpc_pkg::LAYER_HID: if (d < mpc_pkg::N_H2)
                        prod_next[d][s] = mpc_pkg::acc_t'(src[s]) * mpc_pkg::acc_t'(
                            mpc_pkg::quant(mpc_pkg::L2_W[s*mpc_pkg::N_H2+d]));
                    default: if (d < mpc_pkg::N_OUT && s < mpc_pkg::N_H2)
                        prod_next[d][s] = mpc_pkg::acc_t'(src[s]) * mpc_pkg::acc_t'(
                            mpc_pkg::quant(mpc_pkg::L3_W[s*mpc_pkg::N_OUT+d]));
                endcase
            end
        end
    end

    // Sum with bias, then round, apply ReLU except on the output layer, and saturate.
    always_comb begin
        mpc_pkg::acc_t acc;
        for (int d = 0; d < ND; d++) begin
            acc = '0;
            case (layer_sel)
                mpc_pkg::LAYER_IN:
                    acc = mpc_pkg::acc_t'(mpc_pkg::quant(mpc_pkg::L1_B[d]) * 16);
                mpc_pkg::LAYER_HID: if (d < mpc_pkg::N_H2)
                    acc = mpc_pkg::acc_t'(mpc_pkg::quant(mpc_pkg::L2_B[d]) * 16);
                default: if (d < mpc_pkg::N_OUT)
                    acc = mpc_pkg::acc_t'(mpc_pkg::quant(mpc_pkg::L3_B[d]) * 16);
            endcase
            for (int s = 0; s < NS; s++) acc = acc + prod_reg[d][s];
            dst_next[d] = mpc_pkg::scale_sat(acc, layer_sel != mpc_pkg::LAYER_OUT);
        end
    end

    // Advance both stages together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < ND; d++) dst_reg[d] <= '0;
        end else if (adv) begin
            prod_reg <= prod_next;
            dst_reg  <= dst_next;
        end
    end

    assign dst = dst_reg;
endmodule

### rtl/core/mlp_posture_classifier_core.sv
// Pipeline stages: input register, two stages per layer, argmax register;
// throughput one beat per cycle while the output is not stalled.
// The pipeline advances whenever the output register is empty or taken.
// Reset (synchronous, active low) clears all valid bits and drops beats in
// flight; a stall holds every stage, so no beat is lost or repeated.
// -----------------------------------------------------------------------------
// mlp_posture_classifier_core
// 4-8-4-3 perceptron with ReLU and argmax, fully pipelined.
// -----------------------------------------------------------------------------
module mlp_posture_classifier_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mpc_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mpc_pkg::out_beat_t m_data
);
    localparam int NSTG = 8;

    logic [NSTG-1:0] vld_reg;
    logic            adv;
    mpc_pkg::logit_t x_reg [mpc_pkg::N_H1];
    mpc_pkg::logit_t h1 [mpc_pkg::N_H1];
    mpc_pkg::logit_t h2 [mpc_pkg::N_H1];
    mpc_pkg::logit_t y  [mpc_pkg::N_H1];
    mpc_pkg::out_beat_t out_reg;
    mpc_pkg::out_beat_t out_next;

    // Advance when the last stage is free or being taken.
    assign adv     = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NSTG-1];
    assign m_data  = out_reg;

    // Register and widen the features.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0] <= mpc_pkg::logit_t'(s_data.pitch);
            x_reg[1] <= mpc_pkg::logit_t'(s_data.roll);
            x_reg[2] <= mpc_pkg::logit_t'(s_data.pitch_omega);
            x_reg[3] <= mpc_pkg::logit_t'(s_data.roll_omega);
            for (int i = mpc_pkg::N_IN; i < mpc_pkg::N_H1; i++) x_reg[i] <= '0;
            out_reg <= out_next;
        end
    end

    mpc_layer u_l1 (.aclk, .aresetn, .adv, .layer_sel(mpc_pkg::LAYER_IN),
                    .src(x_reg), .dst(h1));
    mpc_layer u_l2 (.aclk, .aresetn, .adv, .layer_sel(mpc_pkg::LAYER_HID),
                    .src(h1), .dst(h2));
    mpc_layer u_l3 (.aclk, .aresetn, .adv, .layer_sel(mpc_pkg::LAYER_OUT),
                    .src(h2), .dst(y));

    // Pick the largest logit, lower index on a tie.
    always_comb begin
        out_next.posture        = mpc_pkg::CLASS_UPRIGHT;
        out_next.score          = y[0];
        if (y[1] > out_next.score) begin
            out_next.posture  = mpc_pkg::CLASS_FORWARD;
            out_next.score    = y[1];
        end
        if (y[2] > out_next.score) begin
            out_next.posture  = mpc_pkg::CLASS_BACKWARD;
            out_next.score    = y[2];
        end
        out_next.logit_upright  = y[0];
        out_next.logit_forward  = y[1];
        out_next.logit_backward = y[2];
    end
endmodule

### rtl/core/mpc_checker.sv
// -----------------------------------------------------------------------------
// mpc_checker
// Port-level checks of the posture classifier, bound to the top level.
// -----------------------------------------------------------------------------
`include "mlp_posture_classifier_core_defines.svh"
module mpc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input mpc_pkg::out_beat_t m_data
);
    // Hold a stalled result beat.
    `MPC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result beat dropped or changed")
    // Hold a waiting input beat.
    `MPC_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid,
        "input beat withdrawn")
    // Accept input whenever output is empty.
    `MPC_ASSERT_NOW(a_ready, aclk, aresetn, !m_valid, s_ready, "stalled with empty output")
    // Never report an unused class.
    `MPC_ASSERT_NOW(a_class, aclk, aresetn, m_valid,
        m_data.posture <= mpc_pkg::CLASS_BACKWARD, "bad class id")
    // Score equals the upright logit when upright is selected.
    `MPC_ASSERT_NOW(a_score, aclk, aresetn,
        m_valid && m_data.posture == mpc_pkg::CLASS_UPRIGHT,
        m_data.score == m_data.logit_upright, "score mismatch")
endmodule

bind mlp_posture_classifier_core mpc_checker u_mpc_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data);

### tb/tb_mlp_posture_classifier_core.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_mlp_posture_classifier_core
// Drives feature vectors into the posture classifier and compares every
// result beat against a behavioral fixed-point network kept in this bench.
// -----------------------------------------------------------------------------
module tb_mlp_posture_classifier_core;

    localparam int FRAC = mpc_pkg::WEIGHT_WIDTH - 2;
    localparam int LW   = mpc_pkg::LOGIT_WIDTH;
    localparam longint CYCLE_LIMIT = 400000;

    // Coefficients in hundredths, [src * dst_count + dst].
    localparam int W1 [32] = '{
         45, -32,  18,  67, -21,  53, -44,  11,
        -38,  72, -15,  29,  61, -47,  33, -56,
         22, -19,  84, -41,  16,  58, -27,  43,
        -51,  36, -63,  25, -34,  71,  48, -17};
    localparam int B1 [8] = '{10, -5, 8, -12, 3, 15, -7, 2};
    localparam int W2 [32] = '{
         39, -28,  52, -17, -43,  61, -35,  24,
         31, -54,  46, -22, -37,  48, -19,  63,
         26, -41,  57, -33, -15,  38, -52,  44,
         49, -23,  36, -58, -31,  55, -42,  27};
    localparam int B2 [4] = '{6, -3, 9, -4};
    localparam int W3 [12] = '{74, -58, -31, -42, 65, -27, 33, -49, 62, -21, 38, 56};
    localparam int B3 [3] = '{15, -8, -5};

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    mpc_pkg::in_beat_t   s_data;
    logic                m_valid;
    logic                m_ready;
    mpc_pkg::out_beat_t  m_data;

    mpc_pkg::in_beat_t   vector_queue[$];
    mpc_pkg::out_beat_t  expected_results[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         error_count;
    int         result_count;
    longint     cycle_count;
    bit         stimulus_done;

    mlp_posture_classifier_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Q1.F coefficient, round half away from zero.
    function automatic longint to_fixed(input int h);
        longint num;
        num = longint'(h) * (longint'(1) << FRAC);
        if (num >= 0) return (num * 2 + 100) / 200;
        return -((-num * 2 + 100) / 200);
    endfunction

    // Round half up to input scale, optional ReLU, saturate.
    function automatic longint rescale_clamp(input longint acc, input bit relu);
        longint v;
        longint hi;
        hi = (longint'(1) <<< (LW - 1)) - 1;
        v = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (relu && v < 0) v = 0;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v;
    endfunction

    function automatic mpc_pkg::out_beat_t classify_posture(input mpc_pkg::in_beat_t x);
        longint f[4];
        longint h1[8];
        longint h2[4];
        longint y[3];
        longint acc;
        int best;
        mpc_pkg::out_beat_t r;
        f[0] = x.pitch; f[1] = x.roll; f[2] = x.pitch_omega; f[3] = x.roll_omega;
        for (int i = 0; i < 8; i++) begin
            acc = to_fixed(B1[i]) * 16;
            for (int j = 0; j < 4; j++) acc += f[j] * to_fixed(W1[j*8+i]);
            h1[i] = rescale_clamp(acc, 1'b1);
        end
        for (int i = 0; i < 4; i++) begin
            acc = to_fixed(B2[i]) * 16;
            for (int j = 0; j < 8; j++) acc += h1[j] * to_fixed(W2[j*4+i]);
            h2[i] = rescale_clamp(acc, 1'b1);
        end
        for (int i = 0; i < 3; i++) begin
            acc = to_fixed(B3[i]) * 16;
            for (int j = 0; j < 4; j++) acc += h2[j] * to_fixed(W3[j*3+i]);
            y[i] = rescale_clamp(acc, 1'b0);
        end
        best = 0;
        for (int i = 1; i < 3; i++) if (y[i] > y[best]) best = i;
        r.posture        = best[1:0];
        r.score          = y[best][LW-1:0];
        r.logit_upright  = y[0][LW-1:0];
        r.logit_forward  = y[1][LW-1:0];
        r.logit_backward = y[2][LW-1:0];
        return r;
    endfunction

    function automatic mpc_pkg::in_beat_t make_vector(input int p, input int r, input int pr,
                                                      input int rr);
        mpc_pkg::in_beat_t v;
        v.pitch = p[15:0]; v.roll = r[15:0];
        v.pitch_omega = pr[15:0]; v.roll_omega = rr[15:0];
        return v;
    endfunction

    // Mostly physical postures, some full-range noise.
    function automatic mpc_pkg::in_beat_t random_vector();
        mpc_pkg::in_beat_t v;
        int span;
        if ($urandom_range(0, 3) == 0) begin
            v = mpc_pkg::in_beat_t'({$urandom, $urandom});
        end else begin
            span = ($urandom_range(0, 1) == 0) ? 1440 : 8000;
            v.pitch       = mpc_pkg::feat_t'($urandom_range(0, 2*span) - span);
            v.roll        = mpc_pkg::feat_t'($urandom_range(0, 2*span) - span);
            v.pitch_omega = mpc_pkg::feat_t'($urandom_range(0, 2*span) - span);
            v.roll_omega  = mpc_pkg::feat_t'($urandom_range(0, 2*span) - span);
        end
        return v;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Driver: present the next vector, hold it until accepted.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(classify_posture(s_data));
            end
            if (vector_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_data  <= vector_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result beat and randomize backpressure.
    always @(posedge aclk) begin
        mpc_pkg::out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_data);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data !== want) begin
                        $display("%0t: mismatch expected cls=%0d score=%0d l=%0d/%0d/%0d",
                                 $time, want.posture, want.score, want.logit_upright,
                                 want.logit_forward, want.logit_backward);
                        $display("%0t:          actual   cls=%0d score=%0d l=%0d/%0d/%0d",
                                 $time, m_data.posture, m_data.score, m_data.logit_upright,
                                 m_data.logit_forward, m_data.logit_backward);
                        error_count <= error_count + 1;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Abort on a hung pipeline.
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) vector_queue.push_back(random_vector());
        wait (vector_queue.size() == 0 && !s_valid);
    endtask

    initial begin
        int corners[8];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        error_count = 0;
        result_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        corners = '{0, 1, -1, 32767, -32768, 16, -16, 1440};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero, single-feature extremes, all-max/all-min, mixed corners.
        vector_queue.push_back(make_vector(0, 0, 0, 0));
        for (int k = 3; k < 5; k++) begin
            vector_queue.push_back(make_vector(corners[k], 0, 0, 0));
            vector_queue.push_back(make_vector(0, corners[k], 0, 0));
            vector_queue.push_back(make_vector(0, 0, corners[k], 0));
            vector_queue.push_back(make_vector(0, 0, 0, corners[k]));
        end
        vector_queue.push_back(make_vector(32767, 32767, 32767, 32767));
        vector_queue.push_back(make_vector(-32768, -32768, -32768, -32768));
        vector_queue.push_back(make_vector(32767, -32768, 32767, -32768));
        vector_queue.push_back(make_vector(-32768, 32767, -32768, 32767));
        vector_queue.push_back(make_vector(-1, -1, -1, -1));
        vector_queue.push_back(make_vector(1, 1, 1, 1));
        vector_queue.push_back(make_vector(480, 0, 0, 0));
        vector_queue.push_back(make_vector(-480, 0, 0, 0));
        vector_queue.push_back(make_vector(0, 480, 0, 0));
        vector_queue.push_back(make_vector(0, -480, 0, 0));
        vector_queue.push_back(make_vector(16, -16, 1440, -1440));
        wait (vector_queue.size() == 0 && !s_valid);

        // Random phases across idle and backpressure mixes.
        run_phase(0, 0, 400);
        run_phase(79, 0, 400);
        run_phase(0, 79, 400);
        run_phase(15, 15, 450);

        wait (expected_results.size() == 0);
        repeat (40) @(posedge aclk);
        $display("Checked %0d classification results over directed corners and",
                 result_count);
        $display("four random phases of source idling and sink backpressure.");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
